>>> design/tps_pkg.sv
// tps_pkg: shared widths, codes and helpers for the trapezoid profile sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package tps_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_BITS  = 32;
   localparam int VEL_BITS  = 31;
   localparam int DT_BITS   = 17;
   localparam int PROG_BITS = 17;
   localparam int OP_BITS   = 33;
   localparam int PROD_BITS = 2 * OP_BITS;
   localparam int NUM_BITS  = 65;
   localparam int ROOT_BITS = 32;
   localparam int CNT_BITS  = $clog2(NUM_BITS + 1);

   localparam logic [PROG_BITS-1:0] PROG_ONE = PROG_BITS'(1) << FRAC_BITS;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [1:0] CSR_MAX_VEL       = 2'd0;
   localparam logic [1:0] CSR_MAX_ACC       = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_PERIOD = 2'd2;

   localparam logic [VEL_BITS-1:0] VEL_RESET = 31'd65536;
   localparam logic [VEL_BITS-1:0] ACC_RESET = 31'd131072;
   localparam logic [DT_BITS-1:0]  DT_RESET  = 17'd655;
   localparam logic [DT_BITS-1:0]  DT_MAX    = 17'd65536;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } iter_ctl_type;

   // shift a product right by FRAC_BITS (or one more) and clamp to 32 bits
   function automatic logic [POS_BITS-1:0] sat_shr(input logic [PROD_BITS-1:0] p,
                                                   input logic extra);
      logic [PROD_BITS-1:0] s;
      s = extra ? (p >> (FRAC_BITS + 1)) : (p >> FRAC_BITS);
      sat_shr = (s[PROD_BITS-1:POS_BITS] != '0) ? '1 : s[POS_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> design/tps_mul.sv
// tps_mul: shared 33x33 unsigned multiplier with a registered product.
// Depends on tps_pkg.
`default_nettype none

module tps_mul import tps_pkg::*; (
   input  wire logic                 clock,
   input  wire logic [OP_BITS-1:0]   op_a,
   input  wire logic [OP_BITS-1:0]   op_b,
   output logic      [PROD_BITS-1:0] prod
);

   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;

   assign prod_in = PROD_BITS'(op_a) * PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> design/tps_iter.sv
// tps_iter: shared shift-subtract unit, restoring divide (one quotient bit a cycle)
// or integer square root (one root bit a cycle). Depends on tps_pkg.
`default_nettype none

module tps_iter import tps_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire iter_ctl_type        ctl,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [OP_BITS-1:0]  den,
   output logic                     done,
   output logic      [NUM_BITS-1:0] quo
);

   localparam logic [CNT_BITS-1:0] DIV_STEPS  = CNT_BITS'(NUM_BITS);
   localparam logic [CNT_BITS-1:0] SQRT_STEPS = CNT_BITS'(ROOT_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  mode_ff, mode_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [33:0]           rem_ff, rem_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [OP_BITS-1:0]    den_ff, den_in;
   logic [35:0]           opa, opb;
   logic [36:0]           diff;
   logic                  borrow;

   // one subtractor serves both modes
   always_comb begin
      opa    = mode_ff ? {rem_ff, num_ff[NUM_BITS-1:NUM_BITS-2]}
                       : {2'b00, rem_ff[32:0], num_ff[NUM_BITS-1]};
      opb    = mode_ff ? {2'b00, root_ff, 2'b01} : {3'b000, den_ff};
      diff   = {1'b0, opa} - {1'b0, opb};
      borrow = diff[36];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      root_in = root_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.sqrt_mode;
         cnt_in  = ctl.sqrt_mode ? SQRT_STEPS : DIV_STEPS;
         rem_in  = '0;
         root_in = '0;
         num_in  = ctl.sqrt_mode ? {num[NUM_BITS-2:0], 1'b0} : num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = borrow ? opa[33:0] : diff[33:0];
         cnt_in = cnt_ff - 1'b1;
         if (mode_ff) begin
            root_in = {root_ff[ROOT_BITS-2:0], ~borrow};
            num_in  = {num_ff[NUM_BITS-3:0], 2'b00};
         end else begin
            num_in = {num_ff[NUM_BITS-2:0], ~borrow};
         end
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      root_ff <= root_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = mode_ff ? {{(NUM_BITS-ROOT_BITS){1'b0}}, root_ff} : num_ff;

endmodule

`default_nettype wire

>>> design/trapezoid_profile_sampler.sv
// trapezoid_profile_sampler: top level, sequencer around the shared multiplier
// and shift-subtract unit. Depends on tps_pkg, tps_mul, tps_iter.
//
// Usage:
//   req_* beats carry a command. A start (cmd 0) takes |goal - current| as the
//   move, plans it from the csr_* registers (max_velocity, max_acceleration,
//   sample_period, written by index with csr_write_en) and returns sample 0.
//   Each tick (cmd 1) returns the next sample's progress (Q1.16) and index; the
//   final sample has progress 1.0 and rsp_last set. A tick with no move open is
//   accepted without leaving idle and returns nothing.
//   One item at a time: req_ready is high only while the sequencer is idle.
//   The shift-subtract unit works one quotient or root bit per cycle (65-bit
//   divides, 32-bit square root). A tick on the final sample skips the
//   arithmetic and goes straight to the output register.
//   The rsp_* output register holds a beat while rsp_ready is low; the next
//   request is accepted meanwhile and its result waits until the slot frees.
//   Reset (synchronous) restores the register defaults, closes any open move
//   and drops a pending response beat.
`default_nettype none

module trapezoid_profile_sampler import tps_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_cmd,
   input  wire logic signed [POS_BITS-1:0]   req_current_pos,
   input  wire logic signed [POS_BITS-1:0]   req_goal_pos,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic             [PROG_BITS-1:0]  rsp_progress,
   output logic             [INDEX_BITS-1:0] rsp_sample_index,
   output logic                              rsp_last,
   input  wire logic                         csr_write_en,
   input  wire logic        [1:0]            csr_index,
   input  wire logic        [VEL_BITS-1:0]   csr_wdata
);

   localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
   localparam int GW = 50;   // width of phase positions before capping

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_P_DA    = 5'd1;
   localparam logic [4:0] S_P_VV    = 5'd2;
   localparam logic [4:0] S_P_CMP   = 5'd3;
   localparam logic [4:0] S_P_TDIV  = 5'd4;
   localparam logic [4:0] S_P_SQRT  = 5'd5;
   localparam logic [4:0] S_P_PK    = 5'd6;
   localparam logic [4:0] S_P_PKW   = 5'd7;
   localparam logic [4:0] S_P_TADIV = 5'd8;
   localparam logic [4:0] S_P_DVDIV = 5'd9;
   localparam logic [4:0] S_P_AD    = 5'd10;
   localparam logic [4:0] S_P_CD    = 5'd11;
   localparam logic [4:0] S_P_TOT   = 5'd12;
   localparam logic [4:0] S_P_CNT   = 5'd13;
   localparam logic [4:0] S_T_T     = 5'd14;
   localparam logic [4:0] S_T_PH    = 5'd15;
   localparam logic [4:0] S_T_C1    = 5'd16;
   localparam logic [4:0] S_T_C2    = 5'd17;
   localparam logic [4:0] S_T_D1    = 5'd18;
   localparam logic [4:0] S_T_D2    = 5'd19;
   localparam logic [4:0] S_T_H1    = 5'd20;
   localparam logic [4:0] S_T_H2    = 5'd21;
   localparam logic [4:0] S_T_H3    = 5'd22;
   localparam logic [4:0] S_T_H4    = 5'd23;
   localparam logic [4:0] S_T_CAP   = 5'd24;
   localparam logic [4:0] S_T_DIV   = 5'd25;
   localparam logic [4:0] S_OUT     = 5'd26;

   logic [4:0]            state_ff, state_in;
   logic [VEL_BITS-1:0]   vel_ff, vel_in, acc_ff, acc_in;
   logic [DT_BITS-1:0]    dt_ff, dt_in;
   logic [POS_BITS-1:0]   dist_ff, dist_in;
   logic [POS_BITS-1:0]   ta_ff, ta_in, tc_ff, tc_in, pk_ff, pk_in;
   logic [POS_BITS-1:0]   ad_ff, ad_in, cd_ff, cd_in;
   logic [INDEX_BITS-1:0] total_ff, total_in, next_ff, next_in;
   logic                  moving_ff, moving_in;
   logic [PROD_BITS-1:0]  p1_ff, p1_in;
   logic [46:0]           ta64_ff, ta64_in;
   logic [POS_BITS-1:0]   h_ff, h_in, m_ff, m_in;
   logic [GW-1:0]         gain_ff, gain_in, pos_ff, pos_in;
   logic                  dec_ff, dec_in;
   logic [PROG_BITS-1:0]  res_prog_ff, res_prog_in;
   logic [INDEX_BITS-1:0] res_idx_ff, res_idx_in;
   logic                  res_last_ff, res_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PROG_BITS-1:0]  rsp_prog_ff, rsp_prog_in;
   logic [INDEX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [VEL_BITS-1:0]   vel_eff, acc_eff;
   logic [DT_BITS-1:0]    dt_eff;
   logic [POS_BITS:0]     diff_w, neg_w;
   logic [POS_BITS-1:0]   dist_w;
   logic                  req_fire;
   logic [OP_BITS-1:0]    mul_a, mul_b;
   logic [PROD_BITS-1:0]  prod, prod_sh, prod_sh1;
   iter_ctl_type          iter_ctl;
   logic [NUM_BITS-1:0]   iter_num, iter_quo;
   logic [OP_BITS-1:0]    iter_den;
   logic                  iter_done;
   logic [63:0]           t64, tmc, rr, sq_x;
   logic [POS_BITS:0]     ta_tc;
   logic [47:0]           dv, tcw;
   logic [PROD_BITS-1:0]  cp1;
   logic [INDEX_BITS:0]   next_p1;
   logic [GW-1:0]         loss;
   logic [POS_BITS-1:0]   pcap;
   logic [34:0]           span;

   tps_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   tps_iter u_iter (
      .clock (clock),
      .reset (reset),
      .ctl   (iter_ctl),
      .num   (iter_num),
      .den   (iter_den),
      .done  (iter_done),
      .quo   (iter_quo)
   );

   always_comb begin
      vel_eff = (vel_ff == '0) ? VEL_BITS'(1) : vel_ff;
      acc_eff = (acc_ff == '0) ? VEL_BITS'(1) : acc_ff;
      if (dt_ff == '0) begin
         dt_eff = DT_BITS'(1);
      end else if (dt_ff > DT_MAX) begin
         dt_eff = DT_MAX;
      end else begin
         dt_eff = dt_ff;
      end
      diff_w   = {req_goal_pos[POS_BITS-1], req_goal_pos}
               - {req_current_pos[POS_BITS-1], req_current_pos};
      neg_w    = '0 - diff_w;
      dist_w   = diff_w[POS_BITS] ? neg_w[POS_BITS-1:0] : diff_w[POS_BITS-1:0];
      req_fire = req_valid && req_ready;
      prod_sh  = prod >> FRAC_BITS;
      prod_sh1 = prod >> (FRAC_BITS + 1);
      t64      = prod[63:0];
      ta_tc    = {1'b0, ta_ff} + {1'b0, tc_ff};
      tmc      = t64 - 64'(ta_ff);
      rr       = t64 - 64'(ta_tc);
      sq_x     = iter_quo[NUM_BITS-1] ? '1 : iter_quo[63:0];
      dv       = iter_quo[47:0];
      tcw      = (dv > {1'b0, ta64_ff}) ? (dv - {1'b0, ta64_ff}) : '0;
      cp1      = PROD_BITS'(iter_quo) + PROD_BITS'(1);
      next_p1  = {1'b0, next_ff} + 1'b1;
      loss     = prod_sh1[GW-1:0];
      pcap     = (pos_ff > GW'(dist_ff)) ? dist_ff : pos_ff[POS_BITS-1:0];
      span     = 35'(ta_ff) + 35'(ta_ff) + 35'(tc_ff) + 35'(dt_eff) - 35'd1;
   end

   // multiplier operands follow the state; the product is read one state later
   always_comb begin
      case (state_ff)
         S_P_DA: begin
            mul_a = OP_BITS'(dist_ff);
            mul_b = OP_BITS'(acc_eff);
         end
         S_P_VV: begin
            mul_a = OP_BITS'(vel_eff);
            mul_b = OP_BITS'(vel_eff);
         end
         S_P_PK, S_T_H1: begin
            mul_a = OP_BITS'(acc_eff);
            mul_b = (state_ff == S_P_PK) ? OP_BITS'(ta_ff) : OP_BITS'(h_ff);
         end
         S_P_AD: begin
            mul_a = OP_BITS'(pk_ff);
            mul_b = OP_BITS'(ta_ff);
         end
         S_P_CD: begin
            mul_a = OP_BITS'(tc_ff);
            mul_b = OP_BITS'(pk_ff);
         end
         S_T_T: begin
            mul_a = OP_BITS'(res_idx_ff);
            mul_b = OP_BITS'(dt_eff);
         end
         S_T_C1, S_T_D1: begin
            mul_a = OP_BITS'(pk_ff);
            mul_b = OP_BITS'(h_ff);
         end
         S_T_H3: begin
            mul_a = OP_BITS'(m_ff);
            mul_b = OP_BITS'(h_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      dt_in        = dt_ff;
      dist_in      = dist_ff;
      ta_in        = ta_ff;
      tc_in        = tc_ff;
      pk_in        = pk_ff;
      ad_in        = ad_ff;
      cd_in        = cd_ff;
      total_in     = total_ff;
      next_in      = next_ff;
      moving_in    = moving_ff;
      p1_in        = p1_ff;
      ta64_in      = ta64_ff;
      h_in         = h_ff;
      m_in         = m_ff;
      gain_in      = gain_ff;
      pos_in       = pos_ff;
      dec_in       = dec_ff;
      res_prog_in  = res_prog_ff;
      res_idx_in   = res_idx_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_prog_in  = rsp_prog_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      iter_ctl     = '0;
      iter_num     = '0;
      iter_den     = '0;

      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_VEL:       vel_in = csr_wdata;
            CSR_MAX_ACC:       acc_in = csr_wdata;
            CSR_SAMPLE_PERIOD: dt_in  = csr_wdata[DT_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_START) begin
                  dist_in  = dist_w;
                  state_in = S_P_DA;
               end else if (moving_ff) begin
                  res_idx_in = next_ff;
                  next_in    = next_p1[INDEX_BITS-1:0];
                  if (next_p1 >= {1'b0, total_ff}) begin
                     res_prog_in = PROG_ONE;
                     res_last_in = 1'b1;
                     moving_in   = 1'b0;
                     state_in    = S_OUT;
                  end else begin
                     res_last_in = 1'b0;
                     state_in    = S_T_T;
                  end
               end
            end
         end
         S_P_DA: state_in = S_P_VV;
         S_P_VV: begin
            p1_in    = prod;
            state_in = S_P_CMP;
         end
         S_P_CMP: begin
            iter_ctl.start = 1'b1;
            iter_den       = OP_BITS'(acc_eff);
            if (p1_ff < prod) begin
               iter_num = NUM_BITS'(dist_ff) << (2 * FRAC_BITS);
               state_in = S_P_TDIV;
            end else begin
               iter_num = NUM_BITS'(vel_eff) << FRAC_BITS;
               state_in = S_P_TADIV;
            end
         end
         S_P_TDIV: begin
            if (iter_done) begin
               iter_ctl.start     = 1'b1;
               iter_ctl.sqrt_mode = 1'b1;
               iter_num           = {1'b0, sq_x};
               state_in           = S_P_SQRT;
            end
         end
         S_P_SQRT: begin
            if (iter_done) begin
               ta_in    = iter_quo[POS_BITS-1:0];
               tc_in    = '0;
               state_in = S_P_PK;
            end
         end
         S_P_PK: state_in = S_P_PKW;
         S_P_PKW: begin
            pk_in    = sat_shr(prod, 1'b0);
            state_in = S_P_AD;
         end
         S_P_TADIV: begin
            if (iter_done) begin
               ta64_in        = iter_quo[46:0];
               iter_ctl.start = 1'b1;
               iter_num       = NUM_BITS'(dist_ff) << FRAC_BITS;
               iter_den       = OP_BITS'(vel_eff);
               state_in       = S_P_DVDIV;
            end
         end
         S_P_DVDIV: begin
            if (iter_done) begin
               ta_in    = (ta64_ff[46:POS_BITS] != '0) ? '1 : ta64_ff[POS_BITS-1:0];
               tc_in    = (tcw[47:POS_BITS] != '0) ? '1 : tcw[POS_BITS-1:0];
               pk_in    = POS_BITS'(vel_eff);
               state_in = S_P_AD;
            end
         end
         S_P_AD: state_in = S_P_CD;
         S_P_CD: begin
            ad_in    = sat_shr(prod, 1'b1);
            state_in = S_P_TOT;
         end
         S_P_TOT: begin
            cd_in          = sat_shr(prod, 1'b0);
            iter_ctl.start = 1'b1;
            iter_num       = NUM_BITS'(span);
            iter_den       = OP_BITS'(dt_eff);
            state_in       = S_P_CNT;
         end
         S_P_CNT: begin
            if (iter_done) begin
               total_in = (cp1 > PROD_BITS'(IDX_MAX)) ? IDX_MAX : cp1[INDEX_BITS-1:0];
               res_idx_in = '0;
               if (total_in <= INDEX_BITS'(1)) begin
                  moving_in   = 1'b0;
                  next_in     = '0;
                  res_prog_in = PROG_ONE;
                  res_last_in = 1'b1;
               end else begin
                  moving_in   = 1'b1;
                  next_in     = INDEX_BITS'(1);
                  res_prog_in = '0;
                  res_last_in = 1'b0;
               end
               state_in = S_OUT;
            end
         end
         S_T_T: state_in = S_T_PH;
         S_T_PH: begin
            // pick the phase from the sample time t
            if (t64 <= 64'(ta_ff)) begin
               h_in     = t64[POS_BITS-1:0];
               dec_in   = 1'b0;
               state_in = S_T_H1;
            end else if (t64 <= 64'(ta_tc)) begin
               h_in     = tmc[POS_BITS-1:0];
               state_in = S_T_C1;
            end else begin
               h_in     = (rr > 64'(ta_ff)) ? ta_ff : rr[POS_BITS-1:0];
               dec_in   = 1'b1;
               state_in = S_T_D1;
            end
         end
         S_T_C1: state_in = S_T_C2;
         S_T_C2: begin
            pos_in   = GW'(ad_ff) + prod_sh[GW-1:0];
            state_in = S_T_CAP;
         end
         S_T_D1: state_in = S_T_D2;
         S_T_D2: begin
            gain_in  = GW'(ad_ff) + GW'(cd_ff) + prod_sh[GW-1:0];
            state_in = S_T_H1;
         end
         S_T_H1: state_in = S_T_H2;
         S_T_H2: begin
            m_in     = sat_shr(prod, 1'b0);
            state_in = S_T_H3;
         end
         S_T_H3: state_in = S_T_H4;
         S_T_H4: begin
            if (dec_ff) begin
               pos_in = (gain_ff > loss) ? (gain_ff - loss) : '0;
            end else begin
               pos_in = loss;
            end
            state_in = S_T_CAP;
         end
         S_T_CAP: begin
            if (dist_ff == '0) begin
               res_prog_in = PROG_ONE;
               state_in    = S_OUT;
            end else begin
               iter_ctl.start = 1'b1;
               iter_num       = NUM_BITS'(pcap) << FRAC_BITS;
               iter_den       = OP_BITS'(dist_ff);
               state_in       = S_T_DIV;
            end
         end
         S_T_DIV: begin
            if (iter_done) begin
               res_prog_in = iter_quo[PROG_BITS-1:0];
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output slot frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prog_in  = res_prog_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_last_in  = res_last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vel_ff       <= VEL_RESET;
         acc_ff       <= ACC_RESET;
         dt_ff        <= DT_RESET;
         total_ff     <= '0;
         next_ff      <= '0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         dt_ff        <= dt_in;
         total_ff     <= total_in;
         next_ff      <= next_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dist_ff     <= dist_in;
      ta_ff       <= ta_in;
      tc_ff       <= tc_in;
      pk_ff       <= pk_in;
      ad_ff       <= ad_in;
      cd_ff       <= cd_in;
      p1_ff       <= p1_in;
      ta64_ff     <= ta64_in;
      h_ff        <= h_in;
      m_ff        <= m_in;
      gain_ff     <= gain_in;
      pos_ff      <= pos_in;
      dec_ff      <= dec_in;
      res_prog_ff <= res_prog_in;
      res_idx_ff  <= res_idx_in;
      res_last_ff <= res_last_in;
      rsp_prog_ff <= rsp_prog_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_progress     = rsp_prog_ff;
   assign rsp_sample_index = rsp_idx_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/tps_checker.sv
// tps_checker: port-level assertions for trapezoid_profile_sampler, with its bind.
// Depends on tps_pkg.
`default_nettype none

module tps_checker import tps_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  req_cmd,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [PROG_BITS-1:0]  rsp_progress,
   input wire logic [INDEX_BITS-1:0] rsp_sample_index,
   input wire logic                  rsp_last
);

   a_reset_drops_beat: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat survived reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_progress)
         && $stable(rsp_sample_index) && $stable(rsp_last))
      else $error("stalled response beat changed");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_progress <= PROG_ONE)
      else $error("progress above one");

   a_last_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_progress == PROG_ONE)
      else $error("final sample not at full progress");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_START |=> !req_ready)
      else $error("ready right after a start beat");

endmodule

bind trapezoid_profile_sampler tps_checker #(.INDEX_BITS(INDEX_BITS)) u_tps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_progress     (rsp_progress),
   .rsp_sample_index (rsp_sample_index),
   .rsp_last         (rsp_last)
);

`default_nettype wire

>>> verif/trapezoid_profile_sampler_checker.sv
// Checker for the trapezoid profile sampler: watches the req, rsp and csr ports,
// predicts every sample from its own copy of the plan and compares. Uses tps_pkg.
`timescale 1ns / 100ps

module trapezoid_profile_sampler_checker import tps_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       req_cmd,
   input  wire logic signed [POS_BITS-1:0] req_current_pos,
   input  wire logic signed [POS_BITS-1:0] req_goal_pos,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [PROG_BITS-1:0]       rsp_progress,
   input  wire logic [15:0]                rsp_sample_index,
   input  wire logic                       rsp_last,
   input  wire logic                       csr_write_en,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [VEL_BITS-1:0]        csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   typedef struct {
      logic [PROG_BITS-1:0] progress;
      logic [15:0]          index;
      logic                 last;
   } sample_type;

   localparam logic [63:0] SAT = 64'hFFFF_FFFF;
   localparam logic [63:0] INDEX_MAX = 64'hFFFF;

   sample_type  expected_samples[$];
   logic [63:0] vel_reg, acc_reg, dt_reg;
   logic [63:0] move_dist, t_acc, t_cruise, peak, d_acc, d_cruise, n_samples;
   logic [15:0] next_idx;
   logic        in_move;

   assign pending = expected_samples.size();

   function automatic logic [63:0] sat32(input logic [63:0] x);
      return (x > SAT) ? SAT : x;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] eff_vel();
      return (vel_reg == 0) ? 64'd1 : vel_reg;
   endfunction

   function automatic logic [63:0] eff_acc();
      return (acc_reg == 0) ? 64'd1 : acc_reg;
   endfunction

   function automatic logic [63:0] eff_dt();
      if (dt_reg == 0) return 64'd1;
      return (dt_reg > 64'd65536) ? 64'd65536 : dt_reg;
   endfunction

   function automatic logic [63:0] half_a_sq(input logic [63:0] a, input logic [63:0] t);
      logic [63:0] m;
      m = sat32((a * t) >> FRAC_BITS);
      return (m * t) >> (FRAC_BITS + 1);
   endfunction

   task automatic plan_move(input logic signed [31:0] cur, input logic signed [31:0] goal);
      longint      diff;
      logic [63:0] d, v, a, ta, tc, pk, q1, r1, x, ta64, dv, total, c;
      diff = longint'(goal) - longint'(cur);
      d = (diff < 0) ? -diff : diff;
      v = eff_vel();
      a = eff_acc();
      if (d * a < v * v) begin
         q1 = (d << FRAC_BITS) / a;
         r1 = (d << FRAC_BITS) % a;
         if ((q1 >> (64 - FRAC_BITS)) != 0) x = '1;
         else x = (q1 << FRAC_BITS) + ((r1 << FRAC_BITS) / a);
         ta = sat32(root_floor(x));
         tc = 0;
         pk = sat32((a * ta) >> FRAC_BITS);
      end else begin
         ta64 = (v << FRAC_BITS) / a;
         dv = (d << FRAC_BITS) / v;
         ta = sat32(ta64);
         tc = sat32((dv > ta64) ? dv - ta64 : 0);
         pk = v;
      end
      move_dist = d;
      t_acc = ta;
      t_cruise = tc;
      peak = pk;
      d_acc = sat32((pk * ta) >> (FRAC_BITS + 1));
      d_cruise = sat32((tc * pk) >> FRAC_BITS);
      total = 2 * ta + tc;
      c = (total + eff_dt() - 1) / eff_dt();
      n_samples = (c + 1 > INDEX_MAX) ? INDEX_MAX : c + 1;
   endtask

   function automatic logic [PROG_BITS-1:0] progress_at(input logic [63:0] i);
      logic [63:0] t, a, pos, r, gain, loss;
      t = i * eff_dt();
      a = eff_acc();
      if (move_dist == 0) return PROG_ONE;
      if (t <= t_acc) begin
         pos = half_a_sq(a, t);
      end else if (t <= t_acc + t_cruise) begin
         pos = d_acc + ((peak * (t - t_acc)) >> FRAC_BITS);
      end else begin
         r = t - t_acc - t_cruise;
         if (r > t_acc) r = t_acc;
         gain = d_acc + d_cruise + ((peak * r) >> FRAC_BITS);
         loss = half_a_sq(a, r);
         pos = (gain > loss) ? gain - loss : 0;
      end
      if (pos > move_dist) pos = move_dist;
      pos = (pos << 16) / move_dist;
      return (pos > 64'd65536) ? PROG_ONE : pos[PROG_BITS-1:0];
   endfunction

   function automatic sample_type make_sample(input logic [PROG_BITS-1:0] p,
                                              input logic [15:0] idx, input logic l);
      sample_type s;
      s.progress = p;
      s.index = idx;
      s.last = l;
      return s;
   endfunction

   // append one predicted beat at the tail of the queue
   function automatic void queue_sample(input sample_type s);
      expected_samples.insert(expected_samples.size(), s);
   endfunction

   always @(posedge clock) begin
      sample_type got, exp_s;
      if (reset) begin
         vel_reg <= 64'(VEL_RESET);
         acc_reg <= 64'(ACC_RESET);
         dt_reg <= 64'(DT_RESET);
         move_dist = 0; t_acc = 0; t_cruise = 0; peak = 0;
         d_acc = 0; d_cruise = 0; n_samples = 0;
         next_idx = 0;
         in_move = 0;
         expected_samples.delete();
      end else begin
         // compare first: a beat leaving now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            got = make_sample(rsp_progress, rsp_sample_index, rsp_last);
            if (expected_samples.size() == 0) begin
               $error("unexpected rsp beat: progress %0d index %0d last %0d",
                      got.progress, got.index, got.last);
               fail_count++;
            end else begin
               exp_s = expected_samples.pop_front();
               if (got.progress !== exp_s.progress) begin
                  $error("progress: expected %0d actual %0d", exp_s.progress, got.progress);
                  fail_count++;
               end
               if (got.index !== exp_s.index) begin
                  $error("sample_index: expected %0d actual %0d", exp_s.index, got.index);
                  fail_count++;
               end
               if (got.last !== exp_s.last) begin
                  $error("last: expected %0d actual %0d", exp_s.last, got.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_START) begin
               plan_move(req_current_pos, req_goal_pos);
               if (n_samples <= 1) begin
                  in_move = 0;
                  next_idx = 0;
                  queue_sample(make_sample(PROG_ONE, 0, 1));
               end else begin
                  in_move = 1;
                  next_idx = 1;
                  queue_sample(make_sample(0, 0, 0));
               end
            end else if (in_move) begin
               if (64'(next_idx) + 1 >= n_samples) begin
                  queue_sample(make_sample(PROG_ONE, next_idx, 1));
                  in_move = 0;
               end else begin
                  queue_sample(make_sample(progress_at(64'(next_idx)), next_idx, 0));
               end
               next_idx = next_idx + 1;
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_MAX_VEL: vel_reg <= 64'(csr_wdata);
               CSR_MAX_ACC: acc_reg <= 64'(csr_wdata);
               CSR_SAMPLE_PERIOD: dt_reg <= 64'(csr_wdata[DT_BITS-1:0]);
               default: ;
            endcase
         end
      end
   end

   initial fail_count = 0;

endmodule

>>> verif/trapezoid_profile_sampler_test.sv
// Top of the trapezoid profile sampler testbench: clock, reset, stimulus and
// verdict. Depends on tps_pkg, the block and trapezoid_profile_sampler_checker.
`timescale 1ns / 100ps

module trapezoid_profile_sampler_test;
   import tps_pkg::*;

   localparam int ITEMS_PER_PHASE = 150;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_cmd;
   logic signed [POS_BITS-1:0] req_current_pos;
   logic signed [POS_BITS-1:0] req_goal_pos;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [PROG_BITS-1:0]       rsp_progress;
   logic [15:0]                rsp_sample_index;
   logic                       rsp_last;
   logic                       csr_write_en;
   logic [1:0]                 csr_index;
   logic [VEL_BITS-1:0]        csr_wdata;
   int                         fail_count;
   int                         pending;

   int send_idle_pct;
   int recv_stall_pct;
   bit long_hold;
   int starts_sent;
   int ticks_sent;

   trapezoid_profile_sampler dut (.*);

   trapezoid_profile_sampler_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stalls, plus one long hold on request
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send(input logic cmd, input logic [31:0] cur, input logic [31:0] goal);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_cmd = cmd;
      req_current_pos = cur;
      req_goal_pos = goal;
      // ready is steady between edges: once seen high, the beat goes at the next edge
      while (!req_ready) @(negedge clock);
      @(negedge clock);
      req_valid = 0;
      if (cmd == CMD_START) starts_sent++;
      else ticks_sent++;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [VEL_BITS-1:0] data);
      csr_write_en = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_write_en = 0;
   endtask

   // hold off until every sample is back and the sequencer has gone quiet
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (260) @(negedge clock);
   endtask

   task automatic set_profile(input logic [30:0] v, input logic [30:0] a,
                              input logic [30:0] dt);
      drain();
      write_csr(CSR_MAX_VEL, v);
      write_csr(CSR_MAX_ACC, a);
      write_csr(CSR_SAMPLE_PERIOD, dt);
   endtask

   task automatic random_phase(input int dist_bits, input int max_ticks);
      int          count, n, mode;
      logic [31:0] cur, span;
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
         mode = count * 4 / ITEMS_PER_PHASE;
         send_idle_pct = (mode == 1) ? 55 : (mode == 3) ? 8 : 0;
         recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 8 : 0;
         if ($urandom_range(99) < 85) begin
            cur = $urandom;
            span = $urandom & ((32'd1 << dist_bits) - 1);
            send(CMD_START, cur, $urandom_range(1) ? cur + span : cur - span);
            count++;
            n = $urandom_range(max_ticks);
            repeat (n) send(CMD_TICK, $urandom, $urandom);
            count += n;
         end else if ($urandom_range(1)) begin
            send(CMD_START, $urandom, $urandom);
            count++;
         end else begin
            send(CMD_TICK, $urandom, $urandom);
            count++;
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_START;
      req_current_pos = 0;
      req_goal_pos = 0;
      csr_write_en = 0;
      csr_index = CSR_MAX_VEL;
      csr_wdata = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold = 0;
      starts_sent = 0;
      ticks_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero move, idle tick, extremes, restart mid-move
      send(CMD_START, 32'd0, 32'd0);
      send(CMD_TICK, 32'd0, 32'd0);
      send(CMD_START, 32'h8000_0000, 32'h7FFF_FFFF);
      repeat (3) send(CMD_TICK, 32'hFFFF_FFFF, 32'h0);
      send(CMD_START, 32'd5, -32'sd5);
      repeat (4) send(CMD_TICK, 32'd0, 32'd0);
      send(CMD_START, 32'h7FFF_FFFF, 32'h8000_0000);
      send(CMD_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(CMD_START, 32'd1000, 32'd1001);
      repeat (4) send(CMD_TICK, 32'd0, 32'd0);

      // short moves; fill the block while the receiver holds off
      set_profile(31'd65536, 31'd131072, 31'd6553);
      long_hold = 1;
      random_phase(17, 30);

      set_profile(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd65536);
      random_phase(32, 6);

      // zero registers act as 1: long saturated moves, few ticks each
      set_profile(31'd0, 31'd0, 31'd0);
      random_phase(3, 4);

      // oversized sample period clamps to one second
      set_profile(31'd1048576, 31'd16777216, 31'd131071);
      random_phase(22, 8);

      set_profile(31'd65536, 31'd131072, 31'd655);
      random_phase(12, 70);

      while (pending != 0) @(negedge clock);
      repeat (260) @(negedge clock);
      $display("Covered %0d starts and %0d ticks over six register settings,",
               starts_sent, ticks_sent);
      $display("with sender gaps, receiver stalls and one long output hold.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/tps_pkg.sv
design/tps_mul.sv
design/tps_iter.sv
design/trapezoid_profile_sampler.sv
design/tps_checker.sv
verif/trapezoid_profile_sampler_checker.sv
verif/trapezoid_profile_sampler_test.sv
